### src/toiir_pkg.sv
// Shared types, constants and helpers for the third-order IIR with gain.
// No dependencies; every file but toiir_chk imports this package.
package toiir_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 17;
  localparam int PROD_W    = 48;
  localparam int ACC_W     = 51;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int N_COEF    = 7;
  localparam int SLOT_W    = 3;
  localparam int SLOTS_PER_CH = 8;
  localparam int Y_SHIFT   = 20;
  localparam int G_SHIFT   = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam logic [SAMPLE_W-1:0] FF0_RESET  = 24'h100000;
  localparam logic [GAIN_W-1:0]   GAIN_RESET = 17'h10000;

  localparam acc_t Y_BIAS = ACC_W'(1) << (Y_SHIFT - 1);
  localparam acc_t G_BIAS = ACC_W'(1) << (G_SHIFT - 1);
  localparam acc_t S_MAX  = ACC_W'(8388607);
  localparam acc_t S_MIN  = -ACC_W'(8388608);

  // register index, byte address / 4
  typedef enum logic [2:0] {
    R_FF0, R_FF1, R_FF2, R_FF3, R_FB1, R_FB2, R_FB3, R_GAIN
  } reg_idx_t;

  typedef struct packed {
    logic [N_COEF-1:0][SAMPLE_W-1:0] coef;  // ff0..ff3, fb1..fb3
    logic [GAIN_W-1:0]               gain;
  } cfg_t;

  // history slots within one channel
  typedef enum logic [SLOT_W-1:0] {
    SL_X1, SL_X2, SL_X3, SL_Y1, SL_Y2, SL_Y3
  } slot_t;

  typedef enum logic [1:0] {A_MEM, A_XIN, A_YREG} asrc_t;
  typedef enum logic [2:0] {
    B_FF0, B_FF1, B_FF2, B_FF3, B_FB1, B_FB2, B_FB3, B_GAIN
  } bsel_t;
  typedef enum logic [1:0] {ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB} accop_t;
  typedef enum logic [1:0] {W_MEM, W_XIN, W_YREG} wsrc_t;
  typedef enum logic [1:0] {OUT_NONE, OUT_GAIN, OUT_ZERO} osel_t;
  typedef enum logic [1:0] {J_NEXT, J_ACCEPT, J_POST} jmp_t;

  typedef logic [3:0] step_t;
  localparam step_t ST_IDLE  = 4'd0;
  localparam step_t ST_FIRST = 4'd1;
  localparam step_t ST_BAD   = 4'd13;

  typedef struct packed {
    logic   rd_en;
    slot_t  rd_slot;
    logic   mul_en;
    asrc_t  a_src;
    bsel_t  b_sel;
    accop_t acc_op;
    logic   wr_en;
    slot_t  wr_slot;
    wsrc_t  w_src;
    logic   rnd_y;
    osel_t  out_sel;
    jmp_t   jmp;
  } ucw_t;

  typedef struct packed {
    ucw_t cw;
    logic take;   // input transaction this cycle
    logic post;   // result loads into the output register
  } seq_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic bad_chan;
    logic out_space;
  } seq_stat_t;

  function automatic sample_t sat_sample(input acc_t v);
    sample_t r;
    if (v > S_MAX)      r = sample_t'(S_MAX);
    else if (v < S_MIN) r = sample_t'(S_MIN);
    else                r = sample_t'(v);
    return r;
  endfunction

endpackage

### src/toiir_if.sv
// Stream interfaces for the input and result channels (valid/ready).
// Depends on toiir_pkg for the sample type.
interface toiir_in_if;
  import toiir_pkg::*;
  logic    valid;
  logic    ready;
  logic    chan;
  sample_t sample_in;
  modport source (output valid, chan, sample_in, input ready);
  modport sink   (input valid, chan, sample_in, output ready);
endinterface

interface toiir_out_if;
  import toiir_pkg::*;
  logic    valid;
  logic    ready;
  logic    chan_out;
  sample_t sample_out;
  modport source (output valid, chan_out, sample_out, input ready);
  modport sink   (input valid, chan_out, sample_out, output ready);
endinterface

### src/toiir_cfg.sv
// APB-style coefficient and gain register file.
// Depends on toiir_pkg.
module toiir_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [toiir_pkg::PADDR_W-1:0] paddr,
  input  logic [toiir_pkg::PDATA_W-1:0] pwdata,
  output logic [toiir_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output toiir_pkg::cfg_t              cfg
);
  import toiir_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // ff0 sits in the low slot; every other tap clears
      cfg_r.coef <= {{(N_COEF-1)*SAMPLE_W{1'b0}}, FF0_RESET};
      cfg_r.gain <= GAIN_RESET;
    end else if (wr) begin
      unique case (idx)
        R_GAIN:  cfg_r.gain <= pwdata[GAIN_W-1:0];
        default: cfg_r.coef[idx] <= pwdata[SAMPLE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      R_GAIN:  prdata = PDATA_W'(cfg_r.gain);
      default: prdata = PDATA_W'($signed(cfg_r.coef[idx]));
    endcase
  end

endmodule

### src/toiir_hist.sv
// Per-channel sample history RAM, one write and one registered read port.
// Valid bits make unwritten entries read as zero after reset. Uses toiir_pkg.
module toiir_hist #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output toiir_pkg::sample_t          rdata,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  toiir_pkg::sample_t          wdata
);
  import toiir_pkg::*;

  sample_t          mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  sample_t          rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

### src/toiir_dp.sv
// Datapath: history RAM, shared 24x24 multiplier, accumulator, rounding,
// output register. Driven by the sequencer control word. Uses toiir_pkg.
module toiir_dp #(
  parameter int CHANNELS = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  toiir_pkg::seq_ctl_t  ctl,
  input  toiir_pkg::cfg_t      cfg,
  input  logic                 in_chan,
  input  toiir_pkg::sample_t   in_sample,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_chan,
  output toiir_pkg::sample_t   out_sample,
  output logic                 out_space
);
  import toiir_pkg::*;

  localparam int DEPTH = CHANNELS * SLOTS_PER_CH;
  localparam int AW    = $clog2(DEPTH);

  ucw_t    cw;
  logic    chan_r;
  sample_t x_r;
  sample_t y_r;
  sample_t rdata;
  sample_t wdata;
  sample_t a_op;
  sample_t b_op;
  logic signed [PROD_W-1:0] prod_r;
  acc_t    acc_r;
  acc_t    prod_ext;
  acc_t    y_rnd;
  acc_t    g_rnd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic    out_valid_r;
  logic    out_chan_r;
  sample_t out_sample_r;

  assign cw = ctl.cw;

  assign rd_addr = AW'({chan_r, cw.rd_slot});
  assign wr_addr = AW'({chan_r, cw.wr_slot});

  always_comb begin
    unique case (cw.w_src)
      W_XIN:   wdata = x_r;
      W_YREG:  wdata = y_r;
      default: wdata = rdata;
    endcase
  end

  toiir_hist #(.DEPTH(DEPTH)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cw.rd_en),
    .rd_addr (rd_addr),
    .rdata   (rdata),
    .wr_en   (cw.wr_en),
    .wr_addr (wr_addr),
    .wdata   (wdata)
  );

  always_comb begin
    unique case (cw.a_src)
      A_XIN:   a_op = x_r;
      A_YREG:  a_op = y_r;
      default: a_op = rdata;
    endcase
    unique case (cw.b_sel)
      B_GAIN:  b_op = $signed(SAMPLE_W'(cfg.gain));
      default: b_op = $signed(cfg.coef[cw.b_sel]);
    endcase
  end

  assign prod_ext = ACC_W'(prod_r);
  // round half up, then clamp to the sample range
  assign y_rnd = (acc_r + Y_BIAS) >>> Y_SHIFT;
  assign g_rnd = (acc_r + G_BIAS) >>> G_SHIFT;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      chan_r <= in_chan;
      x_r    <= in_sample;
    end
    if (cw.mul_en) begin
      prod_r <= a_op * b_op;
    end
    unique case (cw.acc_op)
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      ACC_SUB:  acc_r <= acc_r - prod_ext;
      default:  acc_r <= acc_r;
    endcase
    if (cw.rnd_y) begin
      y_r <= sat_sample(y_rnd);
    end
  end

  assign out_space = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.post) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.post) begin
      out_chan_r   <= chan_r;
      out_sample_r <= (cw.out_sel == OUT_GAIN) ? sat_sample(g_rnd) : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_chan   = out_chan_r;
  assign out_sample = out_sample_r;

endmodule

### src/toiir_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on toiir_pkg for the control word layout.
module toiir_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  toiir_pkg::seq_stat_t stat,
  output toiir_pkg::seq_ctl_t  ctl,
  output logic                 in_ready
);
  import toiir_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  ucw_t  cw;

  function automatic ucw_t rom(input step_t s);
    ucw_t w;
    w = '0;
    unique case (s)
      4'd0:  w.jmp = J_ACCEPT;
      4'd1:  begin
        w.rd_en = 1'b1; w.rd_slot = SL_X3;
        w.mul_en = 1'b1; w.a_src = A_XIN; w.b_sel = B_FF0;
      end
      4'd2:  begin
        w.rd_en = 1'b1; w.rd_slot = SL_X2;
        w.mul_en = 1'b1; w.a_src = A_MEM; w.b_sel = B_FF3;
        w.acc_op = ACC_LOAD;
      end
      4'd3:  begin
        w.rd_en = 1'b1; w.rd_slot = SL_X1;
        w.mul_en = 1'b1; w.a_src = A_MEM; w.b_sel = B_FF2;
        w.acc_op = ACC_ADD;
        w.wr_en = 1'b1; w.wr_slot = SL_X3; w.w_src = W_MEM;
      end
      4'd4:  begin
        w.rd_en = 1'b1; w.rd_slot = SL_Y3;
        w.mul_en = 1'b1; w.a_src = A_MEM; w.b_sel = B_FF1;
        w.acc_op = ACC_ADD;
        w.wr_en = 1'b1; w.wr_slot = SL_X2; w.w_src = W_MEM;
      end
      4'd5:  begin
        w.rd_en = 1'b1; w.rd_slot = SL_Y2;
        w.mul_en = 1'b1; w.a_src = A_MEM; w.b_sel = B_FB3;
        w.acc_op = ACC_ADD;
        w.wr_en = 1'b1; w.wr_slot = SL_X1; w.w_src = W_XIN;
      end
      4'd6:  begin
        w.rd_en = 1'b1; w.rd_slot = SL_Y1;
        w.mul_en = 1'b1; w.a_src = A_MEM; w.b_sel = B_FB2;
        w.acc_op = ACC_SUB;
        w.wr_en = 1'b1; w.wr_slot = SL_Y3; w.w_src = W_MEM;
      end
      4'd7:  begin
        w.mul_en = 1'b1; w.a_src = A_MEM; w.b_sel = B_FB1;
        w.acc_op = ACC_SUB;
        w.wr_en = 1'b1; w.wr_slot = SL_Y2; w.w_src = W_MEM;
      end
      4'd8:  w.acc_op = ACC_SUB;
      4'd9:  w.rnd_y = 1'b1;
      4'd10: begin
        w.mul_en = 1'b1; w.a_src = A_YREG; w.b_sel = B_GAIN;
        w.wr_en = 1'b1; w.wr_slot = SL_Y1; w.w_src = W_YREG;
      end
      4'd11: w.acc_op = ACC_LOAD;
      4'd12: begin
        w.out_sel = OUT_GAIN; w.jmp = J_POST;
      end
      4'd13: begin
        w.out_sel = OUT_ZERO; w.jmp = J_POST;
      end
      default: w.jmp = J_POST;  // unused steps fall back to idle
    endcase
    return w;
  endfunction

  assign cw = rom(pc_r);

  always_comb begin
    ctl.cw   = cw;
    ctl.take = 1'b0;
    ctl.post = 1'b0;
    pc_nxt   = pc_r + 4'd1;
    unique case (cw.jmp)
      J_ACCEPT: begin
        ctl.take = stat.in_valid;
        if (!stat.in_valid)    pc_nxt = pc_r;
        else if (stat.bad_chan) pc_nxt = ST_BAD;
        else                   pc_nxt = ST_FIRST;
      end
      J_POST: begin
        ctl.post = stat.out_space && (cw.out_sel != OUT_NONE);
        pc_nxt   = stat.out_space ? ST_IDLE : pc_r;
      end
      default: pc_nxt = pc_r + 4'd1;
    endcase
  end

  assign in_ready = (cw.jmp == J_ACCEPT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### src/third_order_iir_with_gain.sv
// Third-order direct-form-I IIR filter per channel, followed by a Q1.16
// output gain, with coefficients in an APB-style register file.
//
// Input channel (in_stream): one transaction carries a channel number and a
// Q1.23 sample. Result channel (out_stream): one transaction per input, the
// channel number and the filtered, gain-scaled, saturated sample.
// Registers: ff_coef_0..3, fb_coef_1..3 (Q4.20) and output_gain (Q1.16) at
// byte addresses 0x00..0x1C, written with a setup and an access cycle.
//
// Timing: the result loads into the output register on the last compute step;
// a new input is taken only once the previous result is posted, which waits
// for space in the output register. The input rate is set by the shared
// multiplier (eight products per sample) and the history RAM with one read
// and one write port, sequenced by a 14-step microcode program.
// A channel number outside the configured channel count returns a zero sample
// and leaves the history alone.
// Stall: the output register holds a result until taken; the next input is
// accepted and computed meanwhile, then the sequencer waits on its last step.
// Reset: history reads as zero, coefficients return to a unity pass-through.
module third_order_iir_with_gain #(
  parameter int CHANNELS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  toiir_in_if.sink                      in_stream,
  toiir_out_if.source                   out_stream,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [toiir_pkg::PADDR_W-1:0] paddr,
  input  logic [toiir_pkg::PDATA_W-1:0] pwdata,
  output logic [toiir_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import toiir_pkg::*;

  cfg_t      cfg;
  seq_ctl_t  ctl;
  seq_stat_t stat;
  logic      out_space;

  // Coefficient registers
  toiir_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer status: channel range check happens at the input transaction
  assign stat.in_valid  = in_stream.valid;
  assign stat.bad_chan  = (32'(in_stream.chan) >= CHANNELS);
  assign stat.out_space = out_space;

  toiir_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_stream.ready)
  );

  // Datapath with history RAM and output register
  toiir_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .cfg        (cfg),
    .in_chan    (in_stream.chan),
    .in_sample  (in_stream.sample_in),
    .out_ready  (out_stream.ready),
    .out_valid  (out_stream.valid),
    .out_chan   (out_stream.chan_out),
    .out_sample (out_stream.sample_out),
    .out_space  (out_space)
  );

endmodule

### src/toiir_chk.sv
// Port-level checker for the IIR block, attached by bind.
// Depends on the top level's stream interface ports.
module toiir_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_chan,
  input logic [23:0] out_sample
);

  // result waits, unchanged, until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_chan))
    else $error("result changed while stalled");

  // one sample in flight: no second transaction right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice back to back");

  // posting a result frees the sequencer for the next sample
  a_post_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result posted but input not ready");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind third_order_iir_with_gain toiir_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_stream.valid),
  .in_ready   (in_stream.ready),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .out_chan   (out_stream.chan_out),
  .out_sample (out_stream.sample_out)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the per-channel third-order IIR with output gain.
// Needs toiir_pkg, the stream interfaces and third_order_iir_with_gain.
module testbench;
  import toiir_pkg::*;

  // one channel/sample pair: used for queued inputs and for predicted results
  typedef struct packed {
    logic    chan;
    sample_t sample;
  } chan_sample_t;

  logic clk;
  logic rst_n;

  // register port
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  toiir_in_if  in_if ();
  toiir_out_if out_if ();

  third_order_iir_with_gain #(.CHANNELS(2)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_if),
    .out_stream(out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // ---------------------------------------------------------------------------
  // Filter predictor state: coefficients indexed like the registers
  // (ff0..ff3, fb1..fb3), the gain, and three taps of history per channel.
  // ---------------------------------------------------------------------------
  sample_t           coef [N_COEF];
  logic [GAIN_W-1:0] gain;
  sample_t           x_hist [2][3];
  sample_t           y_hist [2][3];

  chan_sample_t pending_samples [$];  // inputs waiting for the driver
  chan_sample_t filtered_due [$];     // predicted results, oldest first

  int  items_queued = 0;   // inputs ever handed to the driver
  int  results_seen = 0;   // result transactions seen on the output
  int  faults = 0;
  logic in_took = 1'b0;    // input transaction at the last rising edge
  logic jitter_on = 1'b0;  // random idle bursts on both sides
  int  hold_requests = 0;  // long receiver stalls asked for
  int  holds_served = 0;
  int  gap_left = 0;
  int  stall_left = 0;

  function automatic sample_t clamp_q23(longint v);
    if (v > 64'sd8388607) return 24'h7fffff;
    if (v < -64'sd8388608) return 24'h800000;
    return sample_t'(v);
  endfunction

  // Direct-form-I step: exact 64-bit sum, round half up at bit 20, saturate,
  // update history, then apply the Q1.16 gain with the same rounding.
  function automatic chan_sample_t filter_sample(logic ch, sample_t x);
    longint       acc;
    sample_t      y;
    int           k;
    chan_sample_t r;
    acc = longint'(coef[R_FF0]) * longint'(x);
    for (k = 0; k < 3; k++) begin
      acc += longint'(coef[R_FF1 + k]) * longint'(x_hist[ch][k]);
      acc -= longint'(coef[R_FB1 + k]) * longint'(y_hist[ch][k]);
    end
    y = clamp_q23((acc + 64'sd524288) >>> Y_SHIFT);
    x_hist[ch][2] = x_hist[ch][1];
    x_hist[ch][1] = x_hist[ch][0];
    x_hist[ch][0] = x;
    y_hist[ch][2] = y_hist[ch][1];
    y_hist[ch][1] = y_hist[ch][0];
    y_hist[ch][0] = y;
    r.chan   = ch;
    r.sample = clamp_q23((longint'(y) * longint'(gain) + 64'sd32768) >>> G_SHIFT);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input driver: changes at the falling edge. A sample stays offered until a
  // transaction takes it; between samples it may insert a random idle gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    chan_sample_t nxt;
    if (rst_n && !(in_if.valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 2);
        in_if.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        nxt = pending_samples.pop_front();
        in_if.valid     <= 1'b1;
        in_if.chan      <= nxt.chan;
        in_if.sample_in <= nxt.sample;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: short random stalls, plus a long hold-off on request so
  // the output register and the sequencer fill and the input backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (hold_requests != holds_served) begin
        holds_served++;
        stall_left = 79;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, predict on an input transaction and check an
  // output transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    chan_sample_t want;
    in_took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready)
      filtered_due.push_back(filter_sample(in_if.chan, in_if.sample_in));
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (filtered_due.size() == 0) begin
        faults++;
        $display("%0t: unexpected result, expected none, got chan %0d sample %0d",
                 $time, out_if.chan_out, out_if.sample_out);
      end else begin
        want = filtered_due.pop_front();
        if (out_if.chan_out !== want.chan) begin
          faults++;
          $display("%0t: chan_out expected %0d got %0d",
                   $time, want.chan, out_if.chan_out);
        end
        if (out_if.sample_out !== want.sample) begin
          faults++;
          $display("%0t: sample_out expected %0d got %0d",
                   $time, want.sample, out_if.sample_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register access: setup + access write, then a read back of the same
  // register. Only the register's own width is compared on the read.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] mask;
    logic [PDATA_W-1:0] got;
    mask = (idx == R_GAIN) ? 32'h0001ffff : 32'h00ffffff;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == R_GAIN) gain = data[GAIN_W-1:0];
    else coef[idx] = data[SAMPLE_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if ((got & mask) !== (data & mask)) begin
      faults++;
      $display("%0t: register %s read expected %h got %h",
               $time, idx.name(), data & mask, got & mask);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_coef(input reg_idx_t idx, input sample_t v);
    write_reg(idx, {{8{v[SAMPLE_W-1]}}, v});
  endtask

  task automatic queue_item(input logic ch, input sample_t s);
    chan_sample_t it;
    it.chan   = ch;
    it.sample = s;
    pending_samples.push_back(it);
    items_queued++;
  endtask

  // sender pause: nothing new until every queued input has its result back
  task automatic settle();
    while (results_seen < items_queued) @(negedge clk);
  endtask

  function automatic sample_t rand_coef(int unsigned span);
    return sample_t'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return sample_t'($urandom);
    if (pick < 17) return rand_coef(255);
    return pick[0] ? 24'h7fffff : 24'h800000;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    int n;
    int r;
    // predictor and bus at reset values; all block inputs known from time 0
    for (r = 0; r < N_COEF; r++) coef[r] = '0;
    coef[R_FF0] = FF0_RESET;
    gain        = GAIN_RESET;
    for (r = 0; r < 6; r++) begin
      x_hist[r / 3][r % 3] = '0;
      y_hist[r / 3][r % 3] = '0;
    end
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.chan      = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings are a unity pass-through: output equals input
    queue_item(1'b0, 24'h7fffff);
    queue_item(1'b1, 24'h800000);
    queue_item(1'b0, 24'h000000);
    queue_item(1'b1, 24'hffffff);
    queue_item(1'b0, 24'h000001);
    queue_item(1'b1, 24'h555555);
    queue_item(1'b0, 24'haaaaaa);
    settle();

    // extreme coefficients, gain above unity: hard saturation both ways
    for (r = R_FF0; r <= R_FF3; r++) write_coef(reg_idx_t'(r), 24'h7fffff);
    for (r = R_FB1; r <= R_FB3; r++) write_coef(reg_idx_t'(r), 24'h800000);
    write_reg(R_GAIN, 32'h0001ffff);
    queue_item(1'b0, 24'h7fffff);
    queue_item(1'b0, 24'h7fffff);
    queue_item(1'b0, 24'h7fffff);
    queue_item(1'b1, 24'h800000);
    queue_item(1'b1, 24'h800000);
    queue_item(1'b0, 24'h000000);
    settle();

    // opposite extremes with zero gain: output must be zero
    for (r = R_FF0; r <= R_FF3; r++) write_coef(reg_idx_t'(r), 24'h800000);
    for (r = R_FB1; r <= R_FB3; r++) write_coef(reg_idx_t'(r), 24'h7fffff);
    write_reg(R_GAIN, 32'h0);
    queue_item(1'b0, 24'h7fffff);
    queue_item(1'b1, 24'h800000);
    queue_item(1'b0, 24'hffffff);
    queue_item(1'b1, 24'h000001);
    settle();

    // one pole at 0.5, gain just above unity, then the smallest gain
    write_coef(R_FF0, 24'h100000);
    write_coef(R_FF1, 24'h000000);
    write_coef(R_FF2, 24'h000000);
    write_coef(R_FF3, 24'h000000);
    write_coef(R_FB1, 24'hf80000);
    write_coef(R_FB2, 24'h000000);
    write_coef(R_FB3, 24'h000000);
    write_reg(R_GAIN, 32'h00010001);
    queue_item(1'b0, 24'h400000);
    queue_item(1'b0, 24'h000000);
    settle();
    write_reg(R_GAIN, 32'h00000001);
    queue_item(1'b1, 24'h7fffff);
    queue_item(1'b1, 24'hc00000);
    settle();

    // Random phases. Coefficient spread alternates: small (stable, little
    // clipping), full range (mostly saturated), and a full-range ff0 with
    // small remaining taps. Phase 1 carries the long receiver hold-off;
    // phase 3 and the last phase run without any idling.
    for (ph = 0; ph < 6; ph++) begin
      for (r = R_FF0; r <= R_FB3; r++) begin
        case (ph % 3)
          0:       write_coef(reg_idx_t'(r), rand_coef(r >= R_FB1 ? 262144 : 1048576));
          1:       write_coef(reg_idx_t'(r), sample_t'($urandom));
          default: write_coef(reg_idx_t'(r),
                              r == R_FF0 ? sample_t'($urandom) : rand_coef(131072));
        endcase
      end
      write_reg(R_GAIN, $urandom_range(0, 3) == 0 ? 32'h00010000
                                                 : 32'($urandom_range(0, 131071)));
      jitter_on = (ph != 3 && ph != 5);

      for (n = 0; n < 50; n++) queue_item(1'($urandom), rand_sample());
      if (ph == 1) hold_requests++;
      settle();
      // second half: runs on one channel, then both interleaved
      for (n = 0; n < 55; n++)
        queue_item(n < 20 ? 1'(ph) : 1'($urandom), rand_sample());
      settle();
    end

    // drain margin covering the compute latency
    repeat (20) @(posedge clk);
    if (filtered_due.size() != 0) begin
      faults++;
      $display("%0t: %0d results still expected, got none",
               $time, filtered_due.size());
    end
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
src/toiir_pkg.sv
src/toiir_if.sv
src/toiir_cfg.sv
src/toiir_hist.sv
src/toiir_dp.sv
src/toiir_seq.sv
src/third_order_iir_with_gain.sv
src/toiir_chk.sv
tb/testbench.sv
